// ----- hdl/sorted_stream_kway_merge_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted stream k-way merge core
// Concurrent assertion wrappers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef SORTED_STREAM_KWAY_MERGE_CORE_MACROS_SVH
`define SORTED_STREAM_KWAY_MERGE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Assertion sampled on the rising clock, held off while reset is asserted.
`define SKM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion sampled on the rising clock, checked during reset too.
`define SKM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/skm_pkg.sv -----
// ----------------------------------------------------------------------------
// skm_pkg
// Shared constants, payload structs and control structs of the merge core.
// ----------------------------------------------------------------------------
package skm_pkg;

	localparam int NUM_SOURCES = 8;
	localparam int OUT_BLOCK   = 128;

	localparam int SRC_W  = 3;
	localparam int CFG_W  = 4;
	localparam int VAL_W  = 32;
	localparam int MODE_W = 2;
	localparam int LIVE_W = $clog2(NUM_SOURCES + 1);
	localparam int FILL_W = $clog2(OUT_BLOCK + 1);

	localparam logic [CFG_W-1:0] SRC_COUNT_RST = CFG_W'(8);

	localparam logic [MODE_W-1:0] MODE_VALUE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SRC_W-1:0]  source;
		logic [VAL_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic              emitted;
		logic [VAL_W-1:0]  merged_value;
		logic              block_end;
		logic              merge_done;
		logic              order_error;
		logic              want_valid;
		logic [SRC_W-1:0]  want_source;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic emit;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit_ready;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/sorted_stream_kway_merge_core.sv -----
// ----------------------------------------------------------------------------
// sorted_stream_kway_merge_core
// K-way merge of ascending row-id streams into one strictly increasing stream.
// ----------------------------------------------------------------------------
// Usage:
//  - in_data carries one command per transfer (valid/stall): next value of a
//    source, end of a source, or start of a new merge.
//  - out_data returns exactly one status transfer per input transfer,
//    holding the emitted value (if any), block marks, done, the sticky order
//    error and which source must supply its next value (want_source).
//  - cfg_we/cfg_wdata set the live source count; write only while idle.
// Timing:
//  - An emitting command finds the minimum with one 32-bit comparator
//    stepping over the live head registers, one per cycle.
//  - One command is in flight at a time; in_stall is high until its result
//    has been loaded into the output register.
// Reset: clears all heads, end flags, order tracking and the block count; the
// source count returns to 8. Head values themselves are not cleared.
// Stall: a result waits in the output register; the next command may be
// transferred meanwhile, but its result is held back until the first is taken.
// ----------------------------------------------------------------------------
module sorted_stream_kway_merge_core import skm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: one command at a time through check, scan, emit and load
	skm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, comparator and output register
	skm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- hdl/skm_ctrl.sv -----
// ----------------------------------------------------------------------------
// skm_ctrl
// Sequencer: accept, readiness check, minimum scan, emission, result load.
// ----------------------------------------------------------------------------
module skm_ctrl import skm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = stat.emit_ready ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// wait for the output register to free up
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ----- hdl/skm_dp.sv -----
// ----------------------------------------------------------------------------
// skm_dp
// Head registers, source flags, minimum scan unit, order and block tracking.
// ----------------------------------------------------------------------------
`include "sorted_stream_kway_merge_core_macros.svh"

module skm_dp import skm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  cmd_t             cmd,
	output stat_t            stat,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	logic [CFG_W-1:0]       src_count_q;
	logic [VAL_W-1:0]       head_value_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] head_full_q;
	logic [NUM_SOURCES-1:0] ended_q;
	logic                   clear_q;
	logic [VAL_W-1:0]       last_q;
	logic                   any_q;
	logic                   err_q;
	logic [FILL_W-1:0]      fill_q;

	// scan unit
	logic [SRC_W-1:0]       scan_idx_q;
	logic [SRC_W-1:0]       lead_q;
	logic [VAL_W-1:0]       best_q;
	logic                   found_q;

	// per-transfer result
	logic                   emitted_q;
	logic [VAL_W-1:0]       merged_q;
	logic                   blk_end_q;

	logic [LIVE_W-1:0]      live;
	logic [NUM_SOURCES-1:0] live_mask;
	logic                   src_live;
	logic                   val_ok;
	logic                   end_ok;
	logic                   ready;
	logic                   any_full;
	logic                   done;
	logic [NUM_SOURCES-1:0] want_vec;
	logic                   want;
	logic [SRC_W-1:0]       want_src;
	logic [VAL_W-1:0]       scan_rd;
	logic                   take;
	logic [FILL_W-1:0]      fill_inc;
	logic                   flush;

	always_comb begin
		if (LIVE_W'(src_count_q) > LIVE_W'(NUM_SOURCES)) begin
			live = LIVE_W'(NUM_SOURCES);
		end else begin
			live = LIVE_W'(src_count_q);
		end
		for (int i = 0; i < NUM_SOURCES; i++) begin
			live_mask[i] = (LIVE_W'(i) < live);
		end
	end

	assign src_live = (LIVE_W'(in_data.source) < live);
	assign val_ok   = src_live && !ended_q[in_data.source] && !head_full_q[in_data.source];
	assign end_ok   = src_live && !head_full_q[in_data.source];

	assign ready    = &(~live_mask | head_full_q | ended_q);
	assign any_full = |(live_mask & head_full_q);
	assign done     = &(~live_mask | (~head_full_q & ended_q));
	assign want_vec = live_mask & ~head_full_q & ~ended_q;
	assign want     = |want_vec;

	always_comb begin
		want_src = '0;
		for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
			if (want_vec[i]) begin
				want_src = SRC_W'(i);
			end
		end
	end

	assign scan_rd  = head_value_q[scan_idx_q];
	assign take     = head_full_q[scan_idx_q] && (!found_q || (scan_rd < best_q));
	assign fill_inc = fill_q + 1'b1;
	assign flush    = done && (fill_q != '0);

	assign stat.emit_ready = ready && any_full && !clear_q;
	assign stat.scan_last  = (LIVE_W'(scan_idx_q) == (live - 1'b1));
	assign stat.out_free   = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_count_q <= SRC_COUNT_RST;
		end else if (cfg_we) begin
			src_count_q <= cfg_wdata;
		end
	end

	// head values are undefined until written
	always_ff @(posedge clk) begin
		if (cmd.accept && (in_data.mode == MODE_VALUE) && val_ok) begin
			head_value_q[in_data.source] <= in_data.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_full_q <= '0;
			ended_q     <= '0;
			clear_q     <= 1'b0;
		end else if (cmd.accept) begin
			clear_q <= (in_data.mode == MODE_CLEAR);
			unique case (in_data.mode)
				MODE_CLEAR: begin
					head_full_q <= '0;
					ended_q     <= '0;
				end
				MODE_VALUE: begin
					if (val_ok) begin
						head_full_q[in_data.source] <= 1'b1;
					end
				end
				MODE_END: begin
					if (end_ok) begin
						ended_q[in_data.source] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.emit) begin
			head_full_q[lead_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			any_q  <= 1'b0;
			err_q  <= 1'b0;
			fill_q <= '0;
		end else if (cmd.accept && (in_data.mode == MODE_CLEAR)) begin
			last_q <= '0;
			any_q  <= 1'b0;
			err_q  <= 1'b0;
			fill_q <= '0;
		end else if (cmd.emit) begin
			if (any_q && (best_q <= last_q)) begin
				err_q <= 1'b1;
			end
			last_q <= best_q;
			any_q  <= 1'b1;
			fill_q <= (fill_inc == FILL_W'(OUT_BLOCK)) ? '0 : fill_inc;
		end else if (cmd.finish && flush) begin
			fill_q <= '0;
		end
	end

	// scan and per-transfer result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			emitted_q  <= 1'b0;
			blk_end_q  <= 1'b0;
		end else if (cmd.accept) begin
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			emitted_q  <= 1'b0;
			blk_end_q  <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (take) begin
				found_q <= 1'b1;
			end
		end else if (cmd.emit) begin
			emitted_q <= 1'b1;
			blk_end_q <= (fill_inc == FILL_W'(OUT_BLOCK));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			merged_q <= '0;
		end else if (cmd.scan_step && take) begin
			lead_q <= scan_idx_q;
			best_q <= scan_rd;
		end else if (cmd.emit) begin
			merged_q <= best_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data.emitted      <= emitted_q;
			out_data.merged_value <= merged_q;
			out_data.block_end    <= blk_end_q || flush;
			out_data.merge_done   <= done;
			out_data.order_error  <= err_q;
			out_data.want_valid   <= want;
			out_data.want_source  <= want_src;
		end
	end

	`SKM_ASSERT(a_emit_found, clk, arst_n, cmd.emit |-> found_q, "emission without a scanned head")
	`SKM_ASSERT(a_emit_lead_full, clk, arst_n, cmd.emit |-> head_full_q[lead_q], "emitted head not held")
	`SKM_ASSERT(a_fill_range, clk, arst_n, fill_q < FILL_W'(OUT_BLOCK), "block fill out of range")
	`SKM_ASSERT(a_quiet_value, clk, arst_n, (out_valid && !out_data.emitted) |-> (out_data.merged_value == '0), "value on a transfer without emission")

endmodule

// ----- tb/sv/sorted_stream_kway_merge_checker.sv -----
// ----------------------------------------------------------------------------
// sorted_stream_kway_merge_checker
// Watches the command, status and source-count ports of the merge core, keeps
// its own merge state to predict each status transfer, and compares.
// ----------------------------------------------------------------------------
module sorted_stream_kway_merge_checker import skm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int unsigned      outstanding,
	output int unsigned      failures
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_W-1:0] src_count;
	logic [VAL_W-1:0] head_val   [NUM_SOURCES];
	logic             head_full  [NUM_SOURCES];
	logic             src_ended  [NUM_SOURCES];
	logic [VAL_W-1:0] last_val;
	logic             have_last;
	int unsigned      fill;
	logic             err_sticky;
	out_item_t        status_q [$];
	out_item_t        due;

	function automatic void clear_merge();
		for (int i = 0; i < NUM_SOURCES; i++) begin
			head_full[i] = 1'b0;
			src_ended[i] = 1'b0;
		end
		last_val   = '0;
		have_last  = 1'b0;
		fill       = 0;
		err_sticky = 1'b0;
	endfunction

	// apply one command and return the status it should produce
	function automatic out_item_t merge_step(input in_item_t cmd);
		out_item_t r;
		int        live;
		int        lead;
		logic      ready;
		logic      any_full;
		logic      found;
		logic      done;
		r    = '0;
		live = (src_count > NUM_SOURCES) ? NUM_SOURCES : int'(src_count);
		case (cmd.mode)
			MODE_CLEAR: begin
				clear_merge();
			end
			MODE_VALUE: begin
				if (int'(cmd.source) < live && !src_ended[cmd.source] &&
				    !head_full[cmd.source]) begin
					head_val[cmd.source]  = cmd.value;
					head_full[cmd.source] = 1'b1;
				end
			end
			MODE_END: begin
				if (int'(cmd.source) < live && !head_full[cmd.source])
					src_ended[cmd.source] = 1'b1;
			end
			default: begin
			end
		endcase

		if (cmd.mode != MODE_CLEAR) begin
			ready    = 1'b1;
			any_full = 1'b0;
			for (int i = 0; i < live; i++) begin
				if (head_full[i])
					any_full = 1'b1;
				else if (!src_ended[i])
					ready = 1'b0;
			end
			if (ready && any_full) begin
				// strict compare keeps the lowest source on ties
				lead  = 0;
				found = 1'b0;
				for (int i = 0; i < live; i++) begin
					if (head_full[i] && (!found || head_val[i] < head_val[lead])) begin
						lead  = i;
						found = 1'b1;
					end
				end
				r.emitted       = 1'b1;
				r.merged_value  = head_val[lead];
				head_full[lead] = 1'b0;
				if (have_last && head_val[lead] <= last_val)
					err_sticky = 1'b1;
				last_val  = head_val[lead];
				have_last = 1'b1;
				fill++;
				if (fill >= OUT_BLOCK) begin
					r.block_end = 1'b1;
					fill        = 0;
				end
			end
		end

		done = 1'b1;
		for (int i = 0; i < live; i++) begin
			if (head_full[i] || !src_ended[i])
				done = 1'b0;
			if (!r.want_valid && !head_full[i] && !src_ended[i]) begin
				r.want_valid  = 1'b1;
				r.want_source = SRC_W'(i);
			end
		end
		// partial block flushed when the merge runs dry
		if (done && fill > 0) begin
			r.block_end = 1'b1;
			fill        = 0;
		end
		r.merge_done  = done;
		r.order_error = err_sticky;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
	                                    input logic [VAL_W-1:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_count = SRC_COUNT_RST;
			clear_merge();
			status_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				src_count = cfg_wdata;
			// retire before predicting so a same-edge command never matches itself
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					failures++;
					$display("%0t ns: status transfer with nothing expected, expected none, got %h",
					         $time, out_data);
				end else begin
					due = status_q.pop_front();
					check_field("emitted",      VAL_W'(due.emitted),      VAL_W'(out_data.emitted));
					check_field("merged_value", due.merged_value,         out_data.merged_value);
					check_field("block_end",    VAL_W'(due.block_end),    VAL_W'(out_data.block_end));
					check_field("merge_done",   VAL_W'(due.merge_done),   VAL_W'(out_data.merge_done));
					check_field("order_error",  VAL_W'(due.order_error),  VAL_W'(out_data.order_error));
					check_field("want_valid",   VAL_W'(due.want_valid),   VAL_W'(out_data.want_valid));
					check_field("want_source",  VAL_W'(due.want_source),  VAL_W'(out_data.want_source));
				end
			end
			if (in_valid && !in_stall)
				status_q = {status_q, merge_step(in_data)};
			outstanding <= status_q.size();
		end
	end

endmodule

// ----- tb/sv/sorted_stream_kway_merge_core_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_stream_kway_merge_core_tb
// Drives directed and random merge traffic into the k-way merge core under
// random sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module sorted_stream_kway_merge_core_tb import skm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3; // undefined command code
	localparam int ITEMS       = 1600;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int unsigned outstanding;
	int unsigned failures;
	int          cycles = 0;
	int          stall_left = 0;
	int          items_sent = 0;
	int          live_n = NUM_SOURCES;
	bit          burst = 1'b0;

	// stimulus-side view of the merge, only used to pick the next command
	logic [VAL_W-1:0] feed_q [NUM_SOURCES][$];
	logic [VAL_W-1:0] thead  [NUM_SOURCES];
	bit               tfull  [NUM_SOURCES];
	bit               tended [NUM_SOURCES];

	sorted_stream_kway_merge_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sorted_stream_kway_merge_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.outstanding (outstanding),
		.failures    (failures)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short idles, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver back-pressure: each level is held for a random stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= ($urandom_range(0, 99) < 35);
			stall_left <= pause_len();
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// present one command and hold it until the transfer; then maybe idle
	task automatic send(input logic [MODE_W-1:0] mode, input int src,
	                    input logic [VAL_W-1:0] val);
		int gap;
		in_valid       <= 1'b1;
		in_data.mode   <= mode;
		in_data.source <= SRC_W'(src);
		in_data.value  <= val;
		do @(posedge clk); while (in_stall);
		gap = burst ? 0 : pause_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off the sender until every status transfer has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_count(input logic [CFG_W-1:0] n);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
		live_n = (n > NUM_SOURCES) ? NUM_SOURCES : int'(n);
	endtask

	task automatic noise(input int n);
		repeat (n) begin
			send(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 7),
			     $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15));
			items_sent++;
		end
	endtask

	// One merge answered the way the core asks for it. Clean merges keep the
	// sources disjoint (low bits carry the source index); tangled ones give
	// ties, duplicates and backward steps. A cut merge stops part way.
	task automatic run_merge(input int max_len, input bit tangled, input bit cut);
		int               len;
		int               want;
		int               lead;
		int               stop_at;
		int               fed;
		bit               ready;
		bit               any_full;
		logic [63:0]      base;
		logic [VAL_W-1:0] tv;
		logic [VAL_W-1:0] v;
		send(MODE_CLEAR, $urandom_range(0, 7), $urandom);
		items_sent++;
		for (int s = 0; s < NUM_SOURCES; s++) begin
			tfull[s]  = 1'b0;
			tended[s] = 1'b0;
			feed_q[s].delete();
		end
		for (int s = 0; s < live_n; s++) begin
			len  = (max_len >= 20) ? $urandom_range(max_len / 2, max_len)
			                       : $urandom_range(0, max_len);
			base = 64'($urandom >> $urandom_range(3, 31));
			tv   = $urandom_range(0, 5);
			for (int k = 0; k < len; k++) begin
				if (tangled) begin
					tv = ($urandom_range(0, 9) == 0) ? VAL_W'($urandom_range(0, 10))
					                                 : tv + $urandom_range(0, 3);
					feed_q[s] = {feed_q[s], tv};
				end else begin
					if (base >= (64'd1 << 29))
						break;
					feed_q[s] = {feed_q[s], {base[28:0], 3'(s)}};
					base += 64'd1 << $urandom_range(0, 20);
				end
			end
		end
		stop_at = cut ? $urandom_range(1, 12) : -1;
		fed     = 0;
		forever begin
			want = -1;
			for (int s = 0; s < live_n; s++) begin
				if (!tfull[s] && !tended[s]) begin
					want = s;
					break;
				end
			end
			if (want < 0 || fed == stop_at)
				break;
			// now and then a command the core must ignore
			if ($urandom_range(0, 19) == 0) begin
				want = $urandom_range(0, 7);
				if (want >= live_n || tfull[want])
					send($urandom_range(0, 1) ? MODE_VALUE : MODE_END, want, $urandom);
				else if (tended[want])
					send(MODE_VALUE, want, $urandom);
				else
					send(MODE_NONE, want, $urandom);
				items_sent++;
				continue;
			end
			if (feed_q[want].size() == 0) begin
				send(MODE_END, want, $urandom);
				tended[want] = 1'b1;
			end else begin
				v = feed_q[want].pop_front();
				send(MODE_VALUE, want, v);
				tfull[want] = 1'b1;
				thead[want] = v;
			end
			items_sent++;
			fed++;
			// the core pops the smallest head once every live source has spoken
			ready    = 1'b1;
			any_full = 1'b0;
			for (int s = 0; s < live_n; s++) begin
				if (tfull[s])
					any_full = 1'b1;
				else if (!tended[s])
					ready = 1'b0;
			end
			if (ready && any_full) begin
				lead = -1;
				for (int s = 0; s < live_n; s++) begin
					if (tfull[s] && (lead < 0 || thead[s] < thead[lead]))
						lead = s;
				end
				tfull[lead] = 1'b0;
			end
		end
	endtask

	initial begin
		int k;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset source count of eight
		send(MODE_NONE,  7, 32'hFFFF_FFFF);  // unknown code, status only
		send(MODE_END,   7, 32'h0);
		send(MODE_VALUE, 0, 32'hFFFF_FFFF);
		send(MODE_VALUE, 0, 32'h1);          // head already held
		send(MODE_END,   0, 32'h0);          // end while holding a head
		send(MODE_VALUE, 1, 32'h7);
		send(MODE_VALUE, 2, 32'h0);
		send(MODE_VALUE, 3, 32'h0);          // tie with source 2
		send(MODE_VALUE, 4, 32'd100);
		send(MODE_VALUE, 5, 32'd200);
		send(MODE_VALUE, 6, 32'd300);        // all live sources ready: emit
		send(MODE_END,   2, 32'h0);          // tie emits equal value: order fault
		send(MODE_VALUE, 3, 32'h5);
		send(MODE_VALUE, 7, 32'h9);          // source already ended
		send(MODE_CLEAR, 5, 32'hA5A5_A5A5);
		// no live source: done at once
		set_count(4'd0);
		send(MODE_VALUE, 0, 32'h1);
		send(MODE_END,   0, 32'h0);
		// single source, equal values and a partial block flush
		set_count(4'd1);
		send(MODE_CLEAR, 0, 32'h0);
		send(MODE_VALUE, 0, 32'h8000_0000);
		send(MODE_VALUE, 0, 32'h8000_0000);
		send(MODE_END,   0, 32'h0);
		send(MODE_VALUE, 1, 32'h3);          // beyond the live range
		// count above the source total saturates; first merge fills whole blocks
		set_count(4'd15);
		run_merge(40, 1'b0, 1'b0);

		while (items_sent < ITEMS) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 2) == 0)
					set_count(CFG_W'($urandom_range(0, 1) ? 0 : 15));
				else
					set_count(CFG_W'($urandom_range(0, 15)));
			end else if ($urandom_range(0, 9) == 0) begin
				drain();
			end
			k = $urandom_range(0, 9);
			if (k < 2)
				noise($urandom_range(8, 30));
			else
				run_merge((k == 2) ? 40 : $urandom_range(0, 6),
				          $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
		end

		drain();
		// room for any stray status transfer to show up
		repeat (30) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/skm_pkg.sv
hdl/skm_ctrl.sv
hdl/skm_dp.sv
hdl/sorted_stream_kway_merge_core.sv
tb/sv/sorted_stream_kway_merge_checker.sv
tb/sv/sorted_stream_kway_merge_core_tb.sv
